// ===== rtl/positional_pid_integral_clamp_assert.svh =====
// Assertion macros for the PID datapath; only the input stage (ppic_intg) includes them.
`ifndef POSITIONAL_PID_INTEGRAL_CLAMP_ASSERT_SVH
`define POSITIONAL_PID_INTEGRAL_CLAMP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define PPIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define PPIC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/ppic_pkg.sv =====
// Shared constants, register indexes and helper functions of the PID controller.
`default_nettype none

package ppic_pkg;

    // Fixed field widths.
    localparam int GAIN_W           = 16;
    localparam int MAG_W            = GAIN_W + 1;
    localparam int LIMIT_W          = 32;
    localparam int INTEG_W          = 32;
    localparam int OUT_W            = 56;
    localparam int ERROR_WIDTH_DEF  = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 2'd3;

    // Magnitude of a signed gain; the most negative code maps to 2^15.
    function automatic logic [MAG_W-1:0] gain_mag(input logic [GAIN_W-1:0] v);
        logic [MAG_W-1:0] x;
        x = {v[GAIN_W-1], v};
        return v[GAIN_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Magnitude of the signed limit; the most negative code maps to 2^31.
    function automatic logic [LIMIT_W-1:0] limit_mag(input logic [LIMIT_W-1:0] v);
        return v[LIMIT_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/positional_pid_integral_clamp.sv =====
// Positional PID controller with integral clamp: registers, pipeline and output stage.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid/in_ready    error_now (signed, ERROR_WIDTH bits)
//   output   out        out_valid/out_ready  control_out (signed, 56 bits, 8 fraction bits)
//   config   in         cfg_write            cfg_index, cfg_data
//
// One beat is taken per cycle while the input stage can load; its result passes through the
// input stage, then the product registers, then the output register.
// The integral add and clamp sit in the input stage, so the state loop closes within that stage.
// A stall on the output holds each full stage; empty stages still fill, so bubbles close up.
// Reset clears the gains, the limit, the integral and the previous error.
`default_nettype none

module positional_pid_integral_clamp #(
    parameter int ERROR_WIDTH = ppic_pkg::ERROR_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ppic_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppic_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ERROR_WIDTH-1:0]        error_now,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ppic_pkg::OUT_W-1:0]    control_out
);
    import ppic_pkg::*;

    localparam int P_W = MAG_W + ERROR_WIDTH;
    localparam int I_W = MAG_W + INTEG_W;
    localparam int D_W = MAG_W + ERROR_WIDTH + 1;

    logic [MAG_W-1:0]              kp_mag_reg;
    logic [MAG_W-1:0]              ki_mag_reg;
    logic [MAG_W-1:0]              kd_mag_reg;
    logic [LIMIT_W-1:0]            lim_mag_reg;

    logic                          s1_valid;
    logic                          s1_ready;
    logic signed [ERROR_WIDTH-1:0] s1_error;
    logic signed [ERROR_WIDTH:0]   s1_diff;
    logic signed [INTEG_W-1:0]     s1_integ;

    logic                          s2_valid;
    logic                          s2_ready;
    logic signed [P_W-1:0]         s2_prod_p;
    logic signed [I_W-1:0]         s2_prod_i;
    logic signed [D_W-1:0]         s2_prod_d;

    logic                          out_valid_reg;
    logic signed [OUT_W-1:0]       control_reg;
    logic signed [OUT_W-1:0]       control_next;
    logic                          out_en;

    // Configuration registers hold gain and limit magnitudes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_mag_reg  <= '0;
            ki_mag_reg  <= '0;
            kd_mag_reg  <= '0;
            lim_mag_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P:         kp_mag_reg  <= gain_mag(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:         ki_mag_reg  <= gain_mag(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:         kd_mag_reg  <= gain_mag(cfg_data[GAIN_W-1:0]);
                REG_INTEGRAL_LIMIT: lim_mag_reg <= limit_mag(cfg_data[LIMIT_W-1:0]);
                default:            ;
            endcase
        end
    end

    ppic_intg #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_intg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .error_now (error_now),
        .limit_mag (lim_mag_reg),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_error  (s1_error),
        .s1_diff   (s1_diff),
        .s1_integ  (s1_integ)
    );

    ppic_mult #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_error  (s1_error),
        .s1_diff   (s1_diff),
        .s1_integ  (s1_integ),
        .kp_mag    (kp_mag_reg),
        .ki_mag    (ki_mag_reg),
        .kd_mag    (kd_mag_reg),
        .s2_valid  (s2_valid),
        .s2_ready  (s2_ready),
        .s2_prod_p (s2_prod_p),
        .s2_prod_i (s2_prod_i),
        .s2_prod_d (s2_prod_d)
    );

    // Sum of the three products; at the default ERROR_WIDTH the exact result fits the output width.
    assign control_next = OUT_W'(s2_prod_p) + OUT_W'(s2_prod_i) + OUT_W'(s2_prod_d);

    // Output register: loads when empty or when its beat is taken.
    assign out_en   = !out_valid_reg || out_ready;
    assign s2_ready = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s2_valid)
        begin
            control_reg <= control_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign control_out = control_reg;

endmodule

`default_nettype wire

// ===== rtl/ppic_intg.sv =====
// Input stage: integral update with clamp and saturation, derivative difference.
`default_nettype none
`include "positional_pid_integral_clamp_assert.svh"

module ppic_intg #(
    parameter int ERROR_WIDTH = ppic_pkg::ERROR_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ERROR_WIDTH-1:0]       error_now,
    input  logic [ppic_pkg::LIMIT_W-1:0]        limit_mag,
    output logic                                s1_valid,
    input  logic                                s1_ready,
    output logic signed [ERROR_WIDTH-1:0]       s1_error,
    output logic signed [ERROR_WIDTH:0]         s1_diff,
    output logic signed [ppic_pkg::INTEG_W-1:0] s1_integ
);
    import ppic_pkg::*;

    localparam int SUM_W = INTEG_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};

    logic signed [INTEG_W-1:0]     integral_reg;
    logic signed [INTEG_W-1:0]     integral_next;
    logic signed [ERROR_WIDTH-1:0] prev_err_reg;
    logic                          valid_reg;
    logic signed [ERROR_WIDTH-1:0] error_reg;
    logic signed [ERROR_WIDTH:0]   diff_reg;
    logic signed [ERROR_WIDTH:0]   diff_next;
    logic signed [INTEG_W-1:0]     integ_out_reg;
    logic signed [SUM_W-1:0]       sum_raw;
    logic signed [SUM_W-1:0]       sum_clamp;
    logic signed [SUM_W-1:0]       lim_pos;
    logic signed [SUM_W-1:0]       lim_neg;
    logic                          stage_en;
    logic                          in_fire;
    logic signed [INTEG_W:0]       integ_wide;
    logic signed [INTEG_W:0]       lim_wide;

    // The stage loads when it is empty or its beat moves on.
    assign stage_en = !valid_reg || s1_ready;
    assign in_ready = stage_en;
    assign in_fire  = in_valid && stage_en;

    // Exact sum, then the optional limit, then the 32-bit range.
    assign lim_pos = {2'b00, limit_mag};
    assign lim_neg = -lim_pos;
    assign sum_raw = {{(SUM_W-INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg}
                   + {{(SUM_W-ERROR_WIDTH){error_now[ERROR_WIDTH-1]}}, error_now};

    always_comb
    begin
        sum_clamp = sum_raw;
        if (limit_mag != '0)
        begin
            if (sum_raw > lim_pos)
            begin
                sum_clamp = lim_pos;
            end
            else if (sum_raw < lim_neg)
            begin
                sum_clamp = lim_neg;
            end
        end
        if (sum_clamp > SAT_HI)
        begin
            sum_clamp = SAT_HI;
        end
        else if (sum_clamp < SAT_LO)
        begin
            sum_clamp = SAT_LO;
        end
    end

    assign integral_next = sum_clamp[INTEG_W-1:0];

    // Derivative uses the error kept from the previous beat.
    assign diff_next = {error_now[ERROR_WIDTH-1], error_now}
                     - {prev_err_reg[ERROR_WIDTH-1], prev_err_reg};

    // Controller state and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (stage_en)
            begin
                valid_reg <= in_valid;
            end
            if (in_fire)
            begin
                integral_reg <= integral_next;
                prev_err_reg <= error_now;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            error_reg     <= error_now;
            diff_reg      <= diff_next;
            integ_out_reg <= integral_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_error = error_reg;
    assign s1_diff  = diff_reg;
    assign s1_integ = integ_out_reg;

    // Signed views of the integral and the limit for the bound check.
    assign integ_wide = {integral_reg[INTEG_W-1], integral_reg};
    assign lim_wide   = {1'b0, limit_mag};

    `PPIC_ASSERT_NEXT(a_integ_hold, !in_fire, $stable(integral_reg), "integral moved without a beat")
    `PPIC_ASSERT_NEXT(a_prev_err, in_fire, prev_err_reg == $past(error_now), "previous error not kept")
    `PPIC_ASSERT_NEXT(a_clamp, in_fire && limit_mag != '0, integ_wide <= $past(lim_wide) && integ_wide >= -$past(lim_wide), "integral outside its limit")

endmodule

`default_nettype wire

// ===== rtl/ppic_mult.sv =====
// Product stage: the three gain products, each registered.
`default_nettype none

module ppic_mult #(
    parameter int ERROR_WIDTH = ppic_pkg::ERROR_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s1_valid,
    output logic                                   s1_ready,
    input  logic signed [ERROR_WIDTH-1:0]          s1_error,
    input  logic signed [ERROR_WIDTH:0]            s1_diff,
    input  logic signed [ppic_pkg::INTEG_W-1:0]    s1_integ,
    input  logic [ppic_pkg::MAG_W-1:0]             kp_mag,
    input  logic [ppic_pkg::MAG_W-1:0]             ki_mag,
    input  logic [ppic_pkg::MAG_W-1:0]             kd_mag,
    output logic                                   s2_valid,
    input  logic                                   s2_ready,
    output logic signed [ppic_pkg::MAG_W+ERROR_WIDTH-1:0]       s2_prod_p,
    output logic signed [ppic_pkg::MAG_W+ppic_pkg::INTEG_W-1:0] s2_prod_i,
    output logic signed [ppic_pkg::MAG_W+ERROR_WIDTH:0]         s2_prod_d
);
    import ppic_pkg::*;

    localparam int P_W = MAG_W + ERROR_WIDTH;
    localparam int I_W = MAG_W + INTEG_W;
    localparam int D_W = MAG_W + ERROR_WIDTH + 1;

    logic                  valid_reg;
    logic                  stage_en;
    logic signed [P_W-1:0] prod_p_next;
    logic signed [I_W-1:0] prod_i_next;
    logic signed [D_W-1:0] prod_d_next;
    logic signed [P_W-1:0] prod_p_reg;
    logic signed [I_W-1:0] prod_i_reg;
    logic signed [D_W-1:0] prod_d_reg;

    assign stage_en = !valid_reg || s2_ready;
    assign s1_ready = stage_en;

    // Gains are non-negative magnitudes, so each gets a zero sign bit.
    assign prod_p_next = P_W'($signed({1'b0, kp_mag})) * P_W'(s1_error);
    assign prod_i_next = I_W'($signed({1'b0, ki_mag})) * I_W'(s1_integ);
    assign prod_d_next = D_W'($signed({1'b0, kd_mag})) * D_W'(s1_diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_en)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en && s1_valid)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign s2_valid  = valid_reg;
    assign s2_prod_p = prod_p_reg;
    assign s2_prod_i = prod_i_reg;
    assign s2_prod_d = prod_d_reg;

endmodule

`default_nettype wire
